// ===== hdl/elevator_order_dispatch_core_macros.svh =====
// Assertion macros shared by the elevator order dispatch RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ELEVATOR_ORDER_DISPATCH_CORE_MACROS_SVH
`define ELEVATOR_ORDER_DISPATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define EOD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define EOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== hdl/eod_pkg.sv =====
// Shared types and constants for the elevator order dispatch core.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
package eod_pkg;

   localparam int FLOORS = 4;
   localparam int IDX_W  = (FLOORS > 1) ? $clog2(FLOORS) : 1;

   // Operation codes.
   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Button codes, which are also the bit positions in a floor's order bits.
   localparam logic [1:0] BTN_DOWN = 2'd0;
   localparam logic [1:0] BTN_UP   = 2'd1;
   localparam logic [1:0] BTN_CAB  = 2'd2;

   // Direction codes.
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   typedef logic [FLOORS-1:0][2:0] order_table_type;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] floor;
      logic [1:0] button;
      logic       order_value;
      logic [1:0] direction;
   } req_type;

   typedef struct packed {
      logic       any_orders;
      logic       stop_here;
      logic       target_valid;
      logic [1:0] target_floor;
      logic [1:0] move_direction;
   } rsp_type;

   // Control between the request register and the order table.
   typedef struct packed {
      logic    valid;
      req_type req;
   } table_ctrl_type;

endpackage

// ===== hdl/eod_table.sv =====
// Order table: per-floor hall-down, hall-up and cabin bits and their update.
// Depends on eod_pkg. Presents the updated table combinationally to the decision logic.
module eod_table (
   input  logic                      clock,
   input  logic                      reset,
   input  eod_pkg::table_ctrl_type   ctrl,
   output eod_pkg::order_table_type  table_next
);

   eod_pkg::order_table_type order_bits_ff;
   eod_pkg::order_table_type order_bits_in;

   always_comb begin
      logic in_table;
      logic bad_call;
      in_table = (32'(ctrl.req.floor) < eod_pkg::FLOORS);
      bad_call = ((ctrl.req.button == eod_pkg::BTN_DOWN) && (ctrl.req.floor == 2'd0)) ||
                 ((ctrl.req.button == eod_pkg::BTN_UP) &&
                  (32'(ctrl.req.floor) == eod_pkg::FLOORS - 1));
      order_bits_in = order_bits_ff;
      if (ctrl.valid) begin
         case (ctrl.req.op)
            eod_pkg::OP_SET: begin
               for (int f = 0; f < eod_pkg::FLOORS; f++) begin
                  if (in_table && (32'(ctrl.req.floor) == f) && !bad_call) begin
                     for (int b = 0; b < 3; b++) begin
                        if (32'(ctrl.req.button) == b) begin
                           order_bits_in[f][b] = ctrl.req.order_value;
                        end
                     end
                  end
               end
            end
            eod_pkg::OP_REMOVE: begin
               for (int f = 0; f < eod_pkg::FLOORS; f++) begin
                  if (in_table && (32'(ctrl.req.floor) == f)) begin
                     order_bits_in[f][eod_pkg::BTN_CAB] = 1'b0;
                     if (ctrl.req.direction == eod_pkg::DIR_UP) begin
                        order_bits_in[f][eod_pkg::BTN_UP] = 1'b0;
                     end
                     if (ctrl.req.direction == eod_pkg::DIR_DOWN) begin
                        order_bits_in[f][eod_pkg::BTN_DOWN] = 1'b0;
                     end
                  end
               end
            end
            eod_pkg::OP_CLEAR: begin
               order_bits_in = '0;
            end
            default: begin
               order_bits_in = order_bits_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_bits_ff <= '0;
      end else begin
         order_bits_ff <= order_bits_in;
      end
   end

   assign table_next = order_bits_in;

endmodule

// ===== hdl/eod_decide.sv =====
// Stop decision and three-stage target scan over the updated order table.
// Depends on eod_pkg. Purely combinational; the top level registers its result.
module eod_decide (
   input  eod_pkg::req_type          req,
   input  eod_pkg::order_table_type  order_bits,
   output eod_pkg::rsp_type          rsp
);

   typedef struct packed {
      logic                      found;
      logic [eod_pkg::IDX_W-1:0] idx;
   } hit_type;

   // Lowest floor at or above start with its bit set.
   function automatic hit_type scan_up(logic [eod_pkg::FLOORS-1:0] v,
                                       logic [eod_pkg::IDX_W-1:0] start);
      hit_type h;
      h = '0;
      for (int f = eod_pkg::FLOORS - 1; f >= 0; f--) begin
         if (v[f] && (f >= int'(start))) begin
            h.found = 1'b1;
            h.idx   = eod_pkg::IDX_W'(f);
         end
      end
      return h;
   endfunction

   // Highest floor at or below start with its bit set.
   function automatic hit_type scan_down(logic [eod_pkg::FLOORS-1:0] v,
                                         logic [eod_pkg::IDX_W-1:0] start);
      hit_type h;
      h = '0;
      for (int f = 0; f < eod_pkg::FLOORS; f++) begin
         if (v[f] && (f <= int'(start))) begin
            h.found = 1'b1;
            h.idx   = eod_pkg::IDX_W'(f);
         end
      end
      return h;
   endfunction

   localparam logic [eod_pkg::IDX_W-1:0] TOP = eod_pkg::IDX_W'(eod_pkg::FLOORS - 1);

   logic [eod_pkg::FLOORS-1:0] up_cab;
   logic [eod_pkg::FLOORS-1:0] down_cab;
   logic                       in_table;
   logic [eod_pkg::IDX_W-1:0]  cur;
   logic [2:0]                 here;
   hit_type                    target;
   hit_type                    low_down;
   hit_type                    high_up;

   always_comb begin
      for (int f = 0; f < eod_pkg::FLOORS; f++) begin
         up_cab[f]   = order_bits[f][eod_pkg::BTN_UP] | order_bits[f][eod_pkg::BTN_CAB];
         down_cab[f] = order_bits[f][eod_pkg::BTN_DOWN] | order_bits[f][eod_pkg::BTN_CAB];
      end
   end

   assign in_table = (32'(req.floor) < eod_pkg::FLOORS);
   assign cur      = in_table ? eod_pkg::IDX_W'(req.floor) : TOP;
   assign here     = order_bits[cur];
   assign low_down = scan_up(down_cab, '0);
   assign high_up  = scan_down(up_cab, TOP);

   always_comb begin
      hit_type t1;
      hit_type t2;
      hit_type t3;
      t1 = '0;
      t2 = '0;
      t3 = '0;
      case (req.direction)
         eod_pkg::DIR_UP: begin
            t1 = scan_up(up_cab, cur);
            t2 = scan_down(down_cab, TOP);
            t3 = scan_down(up_cab, cur);
         end
         eod_pkg::DIR_DOWN: begin
            t1 = scan_down(down_cab, cur);
            t2 = scan_up(up_cab, '0);
            t3 = scan_up(down_cab, cur);
         end
         default: begin
            t1 = '0;
         end
      endcase
      if (t1.found) begin
         target = t1;
      end else if (t2.found) begin
         target = t2;
      end else begin
         target = t3;
      end
   end

   always_comb begin
      rsp.any_orders = |order_bits;
      rsp.stop_here  = 1'b0;
      if (in_table) begin
         case (req.direction)
            eod_pkg::DIR_UP: begin
               rsp.stop_here = here[eod_pkg::BTN_UP] | here[eod_pkg::BTN_CAB] |
                               (low_down.found && (low_down.idx == cur));
            end
            eod_pkg::DIR_DOWN: begin
               rsp.stop_here = here[eod_pkg::BTN_DOWN] | here[eod_pkg::BTN_CAB] |
                               (high_up.found && (high_up.idx == cur));
            end
            default: begin
               rsp.stop_here = |here;
            end
         endcase
      end
      rsp.target_valid   = target.found;
      rsp.target_floor   = target.found ? 2'(target.idx) : 2'd0;
      rsp.move_direction = eod_pkg::DIR_STOP;
      if (target.found) begin
         if (int'(target.idx) > int'(req.floor)) begin
            rsp.move_direction = eod_pkg::DIR_UP;
         end else if (int'(target.idx) < int'(req.floor)) begin
            rsp.move_direction = eod_pkg::DIR_DOWN;
         end
      end
   end

endmodule

// ===== hdl/elevator_order_dispatch_core.sv =====
// Elevator order dispatch core: a taken request is registered in the request register, and its
// response is registered in the response register, which drives rsp_valid.
// One request per cycle is taken; busy never rises, since the table update and the scan are both
// combinational between the request register and the response register.
// Synchronous active-high reset clears the order table and both valid flags.
// The receiver cannot stall: each response is shown for exactly one cycle.
module elevator_order_dispatch_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  eod_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output eod_pkg::rsp_type  rsp_payload
);

`include "elevator_order_dispatch_core_macros.svh"

   // The request register holds one request while the table and scan logic work on it.
   logic                     req_valid_ff;
   logic                     req_valid_in;
   eod_pkg::req_type         req_ff;
   eod_pkg::req_type         req_in;

   // The response register holds the result for its single strobe cycle.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   eod_pkg::rsp_type         rsp_ff;
   eod_pkg::rsp_type         rsp_in;

   eod_pkg::table_ctrl_type  table_ctrl;
   eod_pkg::order_table_type table_next;

   // Qualified views of the response that the checks below look at.
   logic                     rsp_empty;
   logic                     rsp_quiet;
   logic                     rsp_untargeted;
   logic                     rsp_parked;

   // The table update and scan never hold a request up, so the core can always take another.
   assign busy = 1'b0;

   assign req_valid_in = start && !busy;
   assign req_in       = req_payload;

   assign table_ctrl.valid = req_valid_ff;
   assign table_ctrl.req   = req_ff;

   // The table applies the operation and hands the updated bits on, so the response
   // reflects the state after the update, and the following request sees it too.
   eod_table u_table (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (table_ctrl),
      .table_next (table_next)
   );

   eod_decide u_decide (
      .req        (req_ff),
      .order_bits (table_next),
      .rsp        (rsp_in)
   );

   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign rsp_empty      = rsp_valid && !rsp_payload.any_orders;
   assign rsp_quiet      = !rsp_payload.target_valid && !rsp_payload.stop_here;
   assign rsp_untargeted = rsp_valid && !rsp_payload.target_valid;
   assign rsp_parked     = (rsp_payload.move_direction == eod_pkg::DIR_STOP) &&
                           (rsp_payload.target_floor == 2'd0);

   // Each registered request yields a response strobe on the next cycle.
   `EOD_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid_ff, rsp_valid)

   // An empty table can neither produce a stop nor a target.
   `EOD_ASSERT_NOW(a_empty_no_target, clock, reset, rsp_empty, rsp_quiet)

   // Without a target the car is told to stay where it is.
   `EOD_ASSERT_NOW(a_no_target_no_move, clock, reset, rsp_untargeted, rsp_parked)

endmodule
